// ----- rtl/core/ibt_pkg.sv -----
// ----------------------------------------------------------------------------
// ibt_pkg: shared types and codes for the interval booking table
// Status codes returned per request and the control word that the
// sequencer broadcasts to every storage cell of the chain.
// ----------------------------------------------------------------------------
package ibt_pkg;

    // Result status codes
    localparam logic [1:0] ST_BOOKED  = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Broadcast control to the cell chain
    typedef struct packed {
        logic cmp_en;    // compare stored booking with the held request
        logic shift_en;  // shift the chain by one and load the request at the head
    } cell_ctrl_t;

endpackage

// ----- rtl/core/ibt_cell.sv -----
// ----------------------------------------------------------------------------
// ibt_cell: one storage cell of the booking chain
// Holds one booking, compares it against the broadcast request and passes
// its contents to the next cell when the chain shifts.
// ----------------------------------------------------------------------------
module ibt_cell
    import ibt_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctrl_t           ctrl,
    input  logic                 active,
    input  logic [TIME_BITS-1:0] req_start,
    input  logic [TIME_BITS-1:0] req_end,
    input  logic [TIME_BITS-1:0] prev_start,
    input  logic [TIME_BITS-1:0] prev_end,
    output logic [TIME_BITS-1:0] cell_start,
    output logic [TIME_BITS-1:0] cell_end,
    output logic                 hit
);

    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] end_reg;
    logic                 hit_reg;
    logic                 hit_next;
    logic [TIME_BITS-1:0] lo;
    logic [TIME_BITS-1:0] hi;

    // Overlap: larger start below smaller end
    always_comb begin
        lo       = (start_reg > req_start) ? start_reg : req_start;
        hi       = (end_reg < req_end) ? end_reg : req_end;
        hit_next = active && (lo < hi);
    end

    // Load from the neighbor on shift
    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            start_reg <= prev_start;
            end_reg   <= prev_end;
        end
    end

    // Hold the compare result for the decision cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctrl.cmp_en) begin
            hit_reg <= hit_next;
        end
    end

    assign cell_start = start_reg;
    assign cell_end   = end_reg;
    assign hit        = hit_reg;

endmodule

// ----- rtl/core/interval_booking_table_core.sv -----
// ----------------------------------------------------------------------------
// interval_booking_table_core: reservation table of half-open intervals
// Checks each request against all stored bookings and appends it when free and the table is not full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries one request [s_start_time,
//   s_end_time). Result channel m_valid/m_ready returns one m_status per
//   request: booked, rejected for overlap, or rejected because the table
//   already holds MAX_BOOKINGS entries. Overlap wins over full.
//   Sequence: a request accepted in idle is broadcast to every cell of the
//   chain for compare in the compare state; the decision state then ORs
//   the cell hits, registers the status when the result register is free
//   and shifts the new booking in at the head of the chain.
//   Requests are not overlapped (accept, compare, decide): s_ready
//   is high only while the sequencer idles, so a new request may be taken
//   while the previous status still waits in the output register.
//   When the receiver stalls, the decision cycle holds until the output
//   register is taken; the table is not touched until then.
//   Reset (aresetn low, synchronous) empties the table and drops any pending
//   request and result. Cell contents are not cleared; the fill count marks
//   which cells hold bookings.
// ----------------------------------------------------------------------------
module interval_booking_table_core
    import ibt_pkg::*;
#(
    parameter int MAX_BOOKINGS = 64,
    parameter int TIME_BITS    = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TIME_BITS-1:0] s_start_time,
    input  logic [TIME_BITS-1:0] s_end_time,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status
);

    localparam int CNT_W = $clog2(MAX_BOOKINGS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [TIME_BITS-1:0] req_start_reg;
    logic [TIME_BITS-1:0] req_end_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [1:0]           m_status_reg;
    logic [1:0]           m_status_next;

    cell_ctrl_t           ctrl;
    logic                 any_hit;
    logic                 table_full;
    logic                 out_free;
    logic                 decide;

    logic [TIME_BITS-1:0] chain_start [MAX_BOOKINGS];
    logic [TIME_BITS-1:0] chain_end   [MAX_BOOKINGS];
    logic [MAX_BOOKINGS-1:0] hit_vec;

    // Cell chain: cell 0 takes the request, each other cell its neighbor
    for (genvar i = 0; i < MAX_BOOKINGS; i++) begin : g_cell
        logic [TIME_BITS-1:0] prev_start;
        logic [TIME_BITS-1:0] prev_end;
        logic                 active;

        if (i == 0) begin : g_head
            assign prev_start = req_start_reg;
            assign prev_end   = req_end_reg;
        end else begin : g_body
            assign prev_start = chain_start[i-1];
            assign prev_end   = chain_end[i-1];
        end

        assign active = (count_reg > CNT_W'(i));

        ibt_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .active     (active),
            .req_start  (req_start_reg),
            .req_end    (req_end_reg),
            .prev_start (prev_start),
            .prev_end   (prev_end),
            .cell_start (chain_start[i]),
            .cell_end   (chain_end[i]),
            .hit        (hit_vec[i])
        );
    end

    // Reduce hits and decide
    assign any_hit    = |hit_vec;
    assign table_full = (count_reg == CNT_W'(MAX_BOOKINGS));
    assign out_free   = !m_valid_reg || m_ready;
    assign decide     = (state_reg == S_DEC) && out_free;

    // Sequence the request through compare and decide
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        ctrl.cmp_en   = 1'b0;
        ctrl.shift_en = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ctrl.cmp_en = 1'b1;
                state_next  = S_DEC;
            end
            S_DEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (any_hit) begin
                        m_status_next = ST_OVERLAP;
                    end else if (table_full) begin
                        m_status_next = ST_FULL;
                    end else begin
                        m_status_next = ST_BOOKED;
                        ctrl.shift_en = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        if (s_valid && s_ready) begin
            req_start_reg <= s_start_time;
            req_end_reg   <= s_end_time;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    // Fill count never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BOOKINGS))
        else $error("booking count exceeds table depth");

    // A booked result grows the table by exactly one
    a_book_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (decide && !any_hit && !table_full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("booked request not appended");

    // The table only changes on a booked decision
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(decide && !any_hit && !table_full) |=> $stable(count_reg))
        else $error("table changed without a booking");

    // A result appears only out of the decision cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) && !decide |=> !m_valid_reg)
        else $error("result raised outside decision");

    // Full status only when the table was full
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (decide && !any_hit) |=> (m_status_reg == ST_FULL) == $past(table_full))
        else $error("full status mismatch");

endmodule
